// ===== sv/cuckoo_hash_table_defines.svh =====
// assertion macros used by the checker file
`ifndef CUCKOO_HASH_TABLE_DEFINES_SVH
`define CUCKOO_HASH_TABLE_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define CHT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cuckoo hash table check failed");

// next-cycle implication, sampled on aclk, off while in reset
`define CHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cuckoo hash table check failed");

`endif

// ===== sv/cht_pkg.sv =====
package cht_pkg;

    localparam int KEY_W    = 31;
    localparam int ACT_W    = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_MISS     = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_ZERO     = 2'd3
    } status_t;

endpackage

// ===== sv/cht_ram.sv =====
module cht_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 35,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cht_hash.sv =====
module cht_hash import cht_pkg::*; #(
    parameter int SLOTS = 16,
    localparam int IW = $clog2(SLOTS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [IW-1:0]    h1,
    output logic [IW-1:0]    h2
);

    localparam int SW = $clog2(SLOTS + 1);
    localparam logic [63:0] RECIP = (64'd1 << KEY_W) / SLOTS;
    localparam logic [KEY_W-1:0] RECIP_V = RECIP[KEY_W-1:0];
    localparam logic [SW-1:0] SLOTS_V = SW'(SLOTS);
    localparam logic [KEY_W-1:0] SLOTS_K = KEY_W'(SLOTS);

    typedef enum logic [3:0] {
        H_IDLE  = 4'b0001,
        H_MUL   = 4'b0010,
        H_SCALE = 4'b0100,
        H_FIX   = 4'b1000
    } hstate_t;

    hstate_t hstate_reg, hstate_next;
    logic    pass_reg, pass_next;
    logic    done_reg, done_next;

    logic [KEY_W-1:0]    div_reg;
    logic [2*KEY_W-1:0]  prod1_reg;
    logic [KEY_W-1:0]    qest_reg;
    logic [KEY_W+SW-1:0] prod2_reg;
    logic [IW-1:0]       h1_reg;
    logic [IW-1:0]       h2_reg;

    logic [KEY_W-1:0] rem;
    logic             over;
    logic [KEY_W-1:0] rem_fix;
    logic [KEY_W-1:0] q_fix;

    // estimate undershoots the quotient by at most one
    assign rem     = div_reg - prod2_reg[KEY_W-1:0];
    assign over    = rem >= SLOTS_K;
    assign rem_fix = over ? rem - SLOTS_K : rem;
    assign q_fix   = over ? qest_reg + KEY_W'(1) : qest_reg;

    always_comb begin
        hstate_next = hstate_reg;
        pass_next   = pass_reg;
        done_next   = 1'b0;
        unique case (hstate_reg)
            H_IDLE: begin
                if (start) begin
                    hstate_next = H_MUL;
                    pass_next   = 1'b0;
                end
            end
            H_MUL: begin
                hstate_next = H_SCALE;
            end
            H_SCALE: begin
                hstate_next = H_FIX;
            end
            H_FIX: begin
                if (!pass_reg) begin
                    pass_next   = 1'b1;
                    hstate_next = H_MUL;
                end else begin
                    done_next   = 1'b1;
                    hstate_next = H_IDLE;
                end
            end
            default: begin
                hstate_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hstate_reg <= H_IDLE;
            pass_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            hstate_reg <= hstate_next;
            pass_reg   <= pass_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hstate_reg == H_IDLE && start) begin
            div_reg <= key;
        end
        if (hstate_reg == H_MUL) begin
            prod1_reg <= div_reg * RECIP_V;
        end
        if (hstate_reg == H_SCALE) begin
            qest_reg  <= prod1_reg[2*KEY_W-1:KEY_W];
            prod2_reg <= prod1_reg[2*KEY_W-1:KEY_W] * SLOTS_V;
        end
        if (hstate_reg == H_FIX) begin
            if (!pass_reg) begin
                h1_reg  <= rem_fix[IW-1:0];
                div_reg <= q_fix;
            end else begin
                h2_reg <= rem_fix[IW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign h1   = h1_reg;
    assign h2   = h2_reg;

endmodule

// ===== sv/cuckoo_hash_table.sv =====
// channel   direction  payload                                   handshake
// s_        in         s_action, s_key                           s_valid / s_ready
// m_        out        m_status, m_table_hit, m_slot, m_lost_key m_valid / m_ready
//
// after reset both tables are swept empty, one slot a cycle, with s_ready low
// search, delete or a placing insert: the key passes the hash unit, one table read, one check,
// then the load into the output register; a zero key goes straight to the output register
// an insert that displaces keys adds one displacement step per evicted key, at most MAX_KICKS
// the multiply-and-correct hash unit is shared by both hashes; the table read is registered
// one item at a time; the next item is taken while a result waits in the output register
module cuckoo_hash_table import cht_pkg::*; #(
    parameter int SLOTS = 16,
    parameter int MAX_KICKS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACT_W-1:0]    s_action,
    input  logic [KEY_W-1:0]    s_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_table_hit,
    output logic [SLOT_W-1:0]   m_slot,
    output logic [KEY_W-1:0]    m_lost_key
);

    localparam int IW = $clog2(SLOTS);
    localparam int EW = KEY_W + IW;
    localparam int KW = $clog2(MAX_KICKS + 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_PROBE = 7'b0010000,
        S_RESP  = 7'b0100000,
        S_SPARE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [IW-1:0]    clr_addr_reg, clr_addr_next;
    logic [ACT_W-1:0] act_reg, act_next;
    logic [KEY_W-1:0] cur_key_reg, cur_key_next;
    logic [IW-1:0]    cur_h1_reg, cur_h1_next;
    logic [IW-1:0]    cur_h2_reg, cur_h2_next;
    logic             side_reg, side_next;
    logic [KW-1:0]    kick_cnt_reg, kick_cnt_next;

    status_t          res_status_reg, res_status_next;
    logic             res_table_reg, res_table_next;
    logic [IW-1:0]    res_slot_reg, res_slot_next;
    logic [KEY_W-1:0] res_lost_reg, res_lost_next;

    logic             m_valid_reg, m_valid_next;
    logic             m_load;
    status_t          m_status_reg;
    logic             m_table_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic [KEY_W-1:0] m_lost_reg;

    logic             we1, we2;
    logic [IW-1:0]    waddr1, waddr2, raddr1, raddr2;
    logic [EW-1:0]    wdata1, wdata2, rdata1, rdata2;

    logic             hash_start, hash_done;
    logic [IW-1:0]    hash_h1, hash_h2;

    logic [KEY_W-1:0] rd1_key, rd2_key, probe_key;
    logic [IW-1:0]    rd1_oth, rd2_oth, probe_oth;
    logic             do_kick;

    // each entry holds the key and its slot in the other table
    assign rd1_key   = rdata1[EW-1:IW];
    assign rd1_oth   = rdata1[IW-1:0];
    assign rd2_key   = rdata2[EW-1:IW];
    assign rd2_oth   = rdata2[IW-1:0];
    assign probe_key = side_reg ? rd2_key : rd1_key;
    assign probe_oth = side_reg ? rd2_oth : rd1_oth;

    assign s_ready    = (state_reg == S_IDLE);
    assign hash_start = s_valid && s_ready && (s_key != '0);

    cht_hash #(
        .SLOTS(SLOTS)
    ) u_hash (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (hash_start),
        .key    (s_key),
        .done   (hash_done),
        .h1     (hash_h1),
        .h2     (hash_h2)
    );

    cht_ram #(
        .DEPTH(SLOTS),
        .WIDTH(EW)
    ) u_first (
        .aclk (aclk),
        .we   (we1),
        .waddr(waddr1),
        .wdata(wdata1),
        .raddr(raddr1),
        .rdata(rdata1)
    );

    cht_ram #(
        .DEPTH(SLOTS),
        .WIDTH(EW)
    ) u_second (
        .aclk (aclk),
        .we   (we2),
        .waddr(waddr2),
        .wdata(wdata2),
        .raddr(raddr2),
        .rdata(rdata2)
    );

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        act_next        = act_reg;
        cur_key_next    = cur_key_reg;
        cur_h1_next     = cur_h1_reg;
        cur_h2_next     = cur_h2_reg;
        side_next       = side_reg;
        kick_cnt_next   = kick_cnt_reg;
        res_status_next = res_status_reg;
        res_table_next  = res_table_reg;
        res_slot_next   = res_slot_reg;
        res_lost_next   = res_lost_reg;
        m_load          = 1'b0;
        do_kick         = 1'b0;
        we1             = 1'b0;
        we2             = 1'b0;
        waddr1          = cur_h1_reg;
        waddr2          = cur_h2_reg;
        wdata1          = '0;
        wdata2          = '0;
        raddr1          = cur_h1_reg;
        raddr2          = cur_h2_reg;

        unique case (state_reg)
            S_CLEAR: begin
                we1           = 1'b1;
                we2           = 1'b1;
                waddr1        = clr_addr_reg;
                waddr2        = clr_addr_reg;
                clr_addr_next = clr_addr_reg + IW'(1);
                if (clr_addr_reg == IW'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    act_next        = s_action;
                    cur_key_next    = s_key;
                    side_next       = 1'b0;
                    kick_cnt_next   = '0;
                    res_status_next = ST_OK;
                    res_table_next  = 1'b0;
                    res_slot_next   = '0;
                    res_lost_next   = '0;
                    if (s_key == '0) begin
                        res_status_next = ST_ZERO;
                        state_next      = S_RESP;
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    cur_h1_next = hash_h1;
                    cur_h2_next = hash_h2;
                    raddr1      = hash_h1;
                    raddr2      = hash_h2;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = S_RESP;
                priority if (rd1_key == cur_key_reg) begin
                    if (act_reg != ACT_INSERT) begin
                        res_slot_next = cur_h1_reg;
                    end
                    if (act_reg == ACT_DELETE) begin
                        we1 = 1'b1;
                    end
                end else if (rd2_key == cur_key_reg) begin
                    if (act_reg != ACT_INSERT) begin
                        res_table_next = 1'b1;
                        res_slot_next  = cur_h2_reg;
                    end
                    if (act_reg == ACT_DELETE) begin
                        we2 = 1'b1;
                    end
                end else if (act_reg != ACT_INSERT) begin
                    res_status_next = ST_MISS;
                end else if (rd1_key == '0) begin
                    we1    = 1'b1;
                    wdata1 = {cur_key_reg, cur_h2_reg};
                end else if (rd2_key == '0) begin
                    we2    = 1'b1;
                    wdata2 = {cur_key_reg, cur_h1_reg};
                end else begin
                    do_kick    = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                priority if (probe_key == '0) begin
                    if (!side_reg) begin
                        we1    = 1'b1;
                        wdata1 = {cur_key_reg, cur_h2_reg};
                    end else begin
                        we2    = 1'b1;
                        wdata2 = {cur_key_reg, cur_h1_reg};
                    end
                    state_next = S_RESP;
                end else if (kick_cnt_reg == KW'(MAX_KICKS)) begin
                    res_status_next = ST_OVERFLOW;
                    res_lost_next   = cur_key_reg;
                    state_next      = S_RESP;
                end else begin
                    do_kick = 1'b1;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // evict the occupant of the slot in hand and look up its slot in the other table
        if (do_kick) begin
            kick_cnt_next = kick_cnt_reg + KW'(1);
            cur_key_next  = probe_key;
            side_next     = !side_reg;
            if (!side_reg) begin
                we1         = 1'b1;
                wdata1      = {cur_key_reg, cur_h2_reg};
                cur_h2_next = probe_oth;
                raddr2      = probe_oth;
            end else begin
                we2         = 1'b1;
                wdata2      = {cur_key_reg, cur_h1_reg};
                cur_h1_next = probe_oth;
                raddr1      = probe_oth;
            end
        end

        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (m_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        cur_key_reg    <= cur_key_next;
        cur_h1_reg     <= cur_h1_next;
        cur_h2_reg     <= cur_h2_next;
        side_reg       <= side_next;
        kick_cnt_reg   <= kick_cnt_next;
        res_status_reg <= res_status_next;
        res_table_reg  <= res_table_next;
        res_slot_reg   <= res_slot_next;
        res_lost_reg   <= res_lost_next;
        if (m_load) begin
            m_status_reg <= res_status_reg;
            m_table_reg  <= res_table_reg;
            m_slot_reg   <= SLOT_W'(res_slot_reg);
            m_lost_reg   <= res_lost_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_table_hit = m_table_reg;
    assign m_slot      = m_slot_reg;
    assign m_lost_key  = m_lost_reg;

endmodule

// ===== sv/cht_checker.sv =====
`include "cuckoo_hash_table_defines.svh"

module cht_checker import cht_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic                m_table_hit,
    input logic [SLOT_W-1:0]   m_slot,
    input logic [KEY_W-1:0]    m_lost_key
);

    logic [STATUS_W+SLOT_W+KEY_W:0] out_word;

    assign out_word = {m_status, m_table_hit, m_slot, m_lost_key};

    `CHT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(out_word))
    `CHT_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)
    `CHT_ASSERT_SAME(a_zero_clean, m_valid && m_status == ST_ZERO, !m_table_hit && m_slot == '0)
    `CHT_ASSERT_SAME(a_lost_overflow, m_valid && m_status != ST_OVERFLOW, m_lost_key == '0)
    `CHT_ASSERT_SAME(a_overflow_key, m_valid && m_status == ST_OVERFLOW, m_lost_key != '0)

endmodule

bind cuckoo_hash_table cht_checker u_cht_checker (.*);
